### rtl/kst_pkg.sv
// Package for the keyed set table: request and response payload types,
// request and status codes, and the types passed between the chain cells.
// No dependencies.
`default_nettype none

package kst_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;
  localparam logic [1:0] REQ_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [15:0] payload_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [15:0] payload_out;
    logic [4:0]  entry_count;
  } rsp_t;

  // One stored slot of the table.
  typedef struct packed {
    logic        occupied;
    logic [15:0] key;
    logic [15:0] payload;
  } entry_t;

  // Request token that walks the chain one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [15:0] payload;
    logic        hit;
    logic        placed;
  } tok_t;

endpackage

`default_nettype wire

### rtl/keyed_set_table_core.sv
// Top level of the keyed set table: request intake, the chain of slot
// cells, entry count and the response register with its skid stage.
// Depends on kst_pkg and kst_cell.
//
// Usage: a request (req_type, key, payload_in) transfers on req_valid and
// req_ready; one response (status, found, payload_out, entry_count)
// transfers on rsp_valid and rsp_ready for every request, in order.
// Entries are held packed in insertion order in a row of CAPACITY cells.
// A request enters as a token at the first cell and moves one cell per
// cycle; each cell compares its key, appends, shifts down or pops as the
// token passes. The response is registered after the token has passed
// every cell register, and busy clears as it is registered, so the next
// request is taken only after the token has left the chain; the request
// rate is set by the walk of the token through the chain.
// One request is in the chain at a time. If the receiver stalls, the
// response waits in the output register while the next request may still
// be taken; its response then waits in a skid stage, and req_ready stays
// low until that stage drains.
// Reset (rst, synchronous) empties the table, clears the count and drops
// any pending response.
`default_nettype none

module keyed_set_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire kst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kst_pkg::rsp_t      rsp
);

  kst_pkg::tok_t   tok_chain [kst_pkg::CAPACITY + 1];
  kst_pkg::entry_t ent_chain [kst_pkg::CAPACITY + 1];

  logic                        busy;
  logic                        skid_valid;
  kst_pkg::rsp_t               skid;
  logic [kst_pkg::COUNT_W-1:0] count;
  logic [kst_pkg::COUNT_W-1:0] count_next;
  kst_pkg::rsp_t               res;
  logic                        res_valid;
  logic                        req_xfer;
  logic                        rsp_xfer;
  logic [kst_pkg::CAPACITY-1:0] occ_vec;
  kst_pkg::tok_t               tok_last;

  assign req_ready = !busy && !skid_valid;
  assign req_xfer  = req_valid && req_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;

  always_comb begin
    tok_chain[0].valid    = req_xfer;
    tok_chain[0].req_type = req.req_type;
    tok_chain[0].key      = req.key;
    tok_chain[0].payload  = req.payload_in;
    tok_chain[0].hit      = 1'b0;
    tok_chain[0].placed   = 1'b0;
  end

  assign ent_chain[kst_pkg::CAPACITY] = '0;

  for (genvar i = 0; i < kst_pkg::CAPACITY; i++) begin : g_cell
    kst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .nbr     (ent_chain[i+1]),
      .ent     (ent_chain[i])
    );
    assign occ_vec[i] = ent_chain[i].occupied;
  end

  assign tok_last  = tok_chain[kst_pkg::CAPACITY];
  assign res_valid = tok_last.valid;

  // Resolve the token leaving the chain into a response.
  always_comb begin
    res.status      = kst_pkg::ST_OK;
    res.found       = tok_last.hit;
    res.payload_out = tok_last.hit ? tok_last.payload : 16'd0;
    count_next      = count;
    unique case (tok_last.req_type)
      kst_pkg::REQ_ADD: begin
        if (tok_last.hit) begin
          res.status = kst_pkg::ST_DUP;
        end else if (tok_last.placed) begin
          count_next = count + 1'b1;
        end else begin
          res.status = kst_pkg::ST_FULL;
        end
      end
      kst_pkg::REQ_REMOVE: begin
        if (tok_last.hit) begin
          count_next = count - 1'b1;
        end else if (count == '0) begin
          res.status = kst_pkg::ST_EMPTY;
        end else begin
          res.status = kst_pkg::ST_NOTFOUND;
        end
      end
      kst_pkg::REQ_POP: begin
        if (tok_last.hit) begin
          count_next = count - 1'b1;
        end else begin
          res.status = kst_pkg::ST_EMPTY;
        end
      end
      kst_pkg::REQ_LOOKUP: begin
        if (!tok_last.hit) begin
          res.status = kst_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        res.status = kst_pkg::ST_OK;
      end
    endcase
    res.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      count      <= '0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        busy <= 1'b1;
      end else if (res_valid) begin
        busy <= 1'b0;
      end
      if (res_valid) begin
        count <= count_next;
      end
      // output register and skid stage
      if (res_valid) begin
        if (!rsp_valid || rsp_xfer) begin
          rsp_valid  <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (rsp_xfer) begin
        rsp_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      if (!rsp_valid || rsp_xfer) begin
        rsp <= res;
      end else begin
        skid <= res;
      end
    end else if (rsp_xfer && skid_valid) begin
      rsp <= skid;
    end
  end

  // Held entries stay packed at the low slots.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (occ_vec & (occ_vec + 1'b1)) == '0)
    else $error("occupied slots are not packed");

  // Between requests the count matches the occupied slots.
  a_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> $countones(occ_vec) == 32'(count))
    else $error("entry count disagrees with occupied slots");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid stage holds a response ahead of the output register");

  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> busy && !skid_valid)
    else $error("token left the chain with no request in flight");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> busy && !req_ready)
    else $error("second request taken while one is in the chain");

endmodule

`default_nettype wire

### rtl/kst_cell.sv
// One slot of the keyed set table chain: holds an entry and acts on the
// request token as it passes, then hands the token to the next cell.
// Depends on kst_pkg.
`default_nettype none

module kst_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire kst_pkg::tok_t   tok_in,
  output kst_pkg::tok_t        tok_out,
  input  wire kst_pkg::entry_t nbr,
  output kst_pkg::entry_t      ent
);

  kst_pkg::tok_t   tok_next;
  kst_pkg::entry_t ent_next;
  logic            match;

  assign match = ent.occupied && (ent.key == tok_in.key);

  always_comb begin
    tok_next = tok_in;
    ent_next = ent;
    if (tok_in.valid) begin
      unique case (tok_in.req_type)
        kst_pkg::REQ_ADD: begin
          if (match) begin
            tok_next.hit     = 1'b1;
            tok_next.payload = ent.payload;
          end else if (!ent.occupied && !tok_in.hit && !tok_in.placed) begin
            // first free slot, past every held key: append here
            ent_next.occupied = 1'b1;
            ent_next.key      = tok_in.key;
            ent_next.payload  = tok_in.payload;
            tok_next.placed   = 1'b1;
          end
        end
        kst_pkg::REQ_REMOVE: begin
          if (match) begin
            tok_next.hit     = 1'b1;
            tok_next.payload = ent.payload;
          end
          // close the gap: take the neighbor's entry from the hit onward
          if (match || tok_in.hit) begin
            ent_next = nbr;
          end
        end
        kst_pkg::REQ_POP: begin
          if (ent.occupied && !nbr.occupied) begin
            ent_next.occupied = 1'b0;
            tok_next.hit      = 1'b1;
            tok_next.payload  = ent.payload;
          end
        end
        kst_pkg::REQ_LOOKUP: begin
          if (match) begin
            tok_next.hit     = 1'b1;
            tok_next.payload = ent.payload;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      ent.occupied  <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
      ent.occupied  <= ent_next.occupied;
    end
    tok_out.req_type <= tok_next.req_type;
    tok_out.key      <= tok_next.key;
    tok_out.payload  <= tok_next.payload;
    tok_out.hit      <= tok_next.hit;
    tok_out.placed   <= tok_next.placed;
    ent.key          <= ent_next.key;
    ent.payload      <= ent_next.payload;
  end

endmodule

`default_nettype wire

### dv/tb_keyed_set_table_core.sv
// Testbench for keyed_set_table_core: directed and random set requests with
// random idling on both channels, checked against an in-bench set predictor.
// Depends on kst_pkg and the keyed_set_table_core RTL.
`default_nettype none

module tb_keyed_set_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE = 20;
  localparam int DRAIN_CYCLES = 40;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  kst_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  kst_pkg::rsp_t  rsp;

  // Shadow copy of the table contents
  logic [15:0] held_keys [kst_pkg::CAPACITY];
  logic [15:0] held_payloads [kst_pkg::CAPACITY];
  int          held_count = 0;

  kst_pkg::rsp_t pending_rsps [$];
  logic [15:0]   key_pool [POOL_SIZE];

  int errors = 0;
  int requests_sent = 0;
  int responses_checked = 0;
  int status_tally [5] = '{default: 0};
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_off_cycles = 0;

  keyed_set_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Timeout: %0d requests sent, %0d responses pending", requests_sent,
             pending_rsps.size());
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the shadow table and return the response it yields.
  function automatic kst_pkg::rsp_t apply_set_request(kst_pkg::req_t r);
    kst_pkg::rsp_t res;
    int            pos;
    res = '0;
    res.status = kst_pkg::ST_OK;
    pos = -1;
    for (int i = 0; i < held_count; i++)
      if (pos < 0 && held_keys[i] == r.key) pos = i;
    case (r.req_type)
      kst_pkg::REQ_ADD: begin
        if (pos >= 0) begin
          // duplicate wins over full
          res.status = kst_pkg::ST_DUP;
          res.found = 1'b1;
          res.payload_out = held_payloads[pos];
        end else if (held_count >= kst_pkg::CAPACITY) begin
          res.status = kst_pkg::ST_FULL;
        end else begin
          held_keys[held_count] = r.key;
          held_payloads[held_count] = r.payload_in;
          held_count++;
        end
      end
      kst_pkg::REQ_REMOVE: begin
        if (held_count == 0) begin
          res.status = kst_pkg::ST_EMPTY;
        end else if (pos < 0) begin
          res.status = kst_pkg::ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          res.payload_out = held_payloads[pos];
          for (int j = pos + 1; j < held_count; j++) begin
            held_keys[j - 1] = held_keys[j];
            held_payloads[j - 1] = held_payloads[j];
          end
          held_count--;
        end
      end
      kst_pkg::REQ_POP: begin
        if (held_count == 0) begin
          res.status = kst_pkg::ST_EMPTY;
        end else begin
          held_count--;
          res.found = 1'b1;
          res.payload_out = held_payloads[held_count];
        end
      end
      default: begin
        if (pos >= 0) begin
          res.found = 1'b1;
          res.payload_out = held_payloads[pos];
        end else begin
          res.status = kst_pkg::ST_NOTFOUND;
        end
      end
    endcase
    res.entry_count = 5'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Offer one request and hold it until the transfer; leave valid high.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] k,
                              input logic [15:0] pl);
    kst_pkg::req_t item;
    int            gap;
    item.req_type = kind;
    item.key = k;
    item.payload_in = pl;
    gap = sender_idle ? idle_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    pending_rsps.push_back(apply_set_request(item));
    requests_sent++;
  endtask

  function automatic void refresh_key_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
  endfunction

  // Keys mostly come from a small pool so that hits and duplicates are common.
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_request(kst_pkg::REQ_LOOKUP, 16'h0000, 16'h0000);   // lookup on empty set
    send_request(kst_pkg::REQ_REMOVE, 16'hFFFF, 16'hFFFF);   // remove on empty set
    send_request(kst_pkg::REQ_POP,    16'h0000, 16'h0000);   // pop on empty set
    send_request(kst_pkg::REQ_ADD,    16'h0000, 16'hFFFF);
    send_request(kst_pkg::REQ_ADD,    16'hFFFF, 16'h0000);
    send_request(kst_pkg::REQ_ADD,    16'h0000, 16'h1234);   // duplicate keeps old payload
    send_request(kst_pkg::REQ_LOOKUP, 16'hFFFF, 16'h0000);
    send_request(kst_pkg::REQ_LOOKUP, 16'h0001, 16'h0000);   // miss on non-empty set
    send_request(kst_pkg::REQ_REMOVE, 16'h0005, 16'h0000);   // miss on non-empty set
    for (int i = 1; i <= kst_pkg::CAPACITY - 2; i++)
      send_request(kst_pkg::REQ_ADD, 16'(i * 16'h1111), 16'(16'hA000 + i));
    send_request(kst_pkg::REQ_ADD,    16'h8000, 16'h5555);   // table full
    send_request(kst_pkg::REQ_ADD,    16'hFFFF, 16'hAAAA);   // duplicate while full
    send_request(kst_pkg::REQ_REMOVE, 16'h0000, 16'h0000);   // head removal shifts all
    send_request(kst_pkg::REQ_LOOKUP, 16'h5555, 16'h0000);
    send_request(kst_pkg::REQ_POP,    16'h0000, 16'h0000);
  endtask

  task automatic test_random_mix(input int n);
    int r;
    logic [1:0] kind;
    refresh_key_pool();
    for (int i = 0; i < n; i++) begin
      // first stretch runs with no idling on either side
      sender_idle = (i >= 200);
      receiver_idle = (i >= 200);
      r = $urandom_range(0, 99);
      kind = (r < 35) ? kst_pkg::REQ_ADD :
             (r < 55) ? kst_pkg::REQ_REMOVE :
             (r < 65) ? kst_pkg::REQ_POP : kst_pkg::REQ_LOOKUP;
      send_request(kind, pick_key(), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    sender_idle = 1'b0;
    hold_off_cycles = 300;
    for (int i = 0; i < 12; i++)
      send_request(2'($urandom_range(0, 3)), pick_key(), 16'($urandom));
    sender_idle = 1'b1;
  endtask

  // Alternate add-heavy and drain-heavy stretches to sweep the fill level.
  task automatic test_fill_drain(input int n);
    int r;
    logic [1:0] kind;
    for (int i = 0; i < n; i++) begin
      if (i % 96 == 0) refresh_key_pool();
      r = $urandom_range(0, 99);
      if ((i / 24) % 2 == 0)
        kind = (r < 80) ? kst_pkg::REQ_ADD : kst_pkg::REQ_LOOKUP;
      else
        kind = (r < 45) ? kst_pkg::REQ_REMOVE :
               (r < 80) ? kst_pkg::REQ_POP : kst_pkg::REQ_LOOKUP;
      send_request(kind, pick_key(), 16'($urandom));
    end
  endtask

  initial begin
    int n;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    kst_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (rsp.status !== exp_rsp.status)
          report_mismatch($sformatf("rsp %0d status got %0d expected %0d",
                                    responses_checked, rsp.status, exp_rsp.status));
        if (rsp.found !== exp_rsp.found)
          report_mismatch($sformatf("rsp %0d found got %0b expected %0b",
                                    responses_checked, rsp.found, exp_rsp.found));
        if (rsp.payload_out !== exp_rsp.payload_out)
          report_mismatch($sformatf("rsp %0d payload_out got %h expected %h",
                                    responses_checked, rsp.payload_out, exp_rsp.payload_out));
        if (rsp.entry_count !== exp_rsp.entry_count)
          report_mismatch($sformatf("rsp %0d entry_count got %0d expected %0d",
                                    responses_checked, rsp.entry_count, exp_rsp.entry_count));
        if (exp_rsp.status <= kst_pkg::ST_FULL) status_tally[exp_rsp.status]++;
        responses_checked++;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(1000);
    test_backpressure();
    test_fill_drain(900);
    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses", requests_sent, responses_checked);
    $display("Status mix: ok %0d, duplicate %0d, not found %0d, empty %0d, full %0d",
             status_tally[kst_pkg::ST_OK], status_tally[kst_pkg::ST_DUP],
             status_tally[kst_pkg::ST_NOTFOUND], status_tally[kst_pkg::ST_EMPTY],
             status_tally[kst_pkg::ST_FULL]);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/kst_pkg.sv
rtl/kst_cell.sv
rtl/keyed_set_table_core.sv
dv/tb_keyed_set_table_core.sv
